>>> src/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants for the coverage histogram block
// Beat formats, opcodes, queue entry and the status passed from back to front.
// ----------------------------------------------------------------------------
package chs_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_READ   = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [13:0] count_a;
    logic [13:0] count_g;
    logic [13:0] count_c;
    logic [13:0] count_t;
    logic [9:0]  bin_index;
  } item_t;

  typedef struct packed {
    logic [15:0] coverage;
    logic [31:0] bin_count;
    logic [23:0] mean_q8;
    logic [23:0] std_q8;
    logic [31:0] positions;
    logic        empty_res;
    logic        clipped;
  } result_t;

  // classified item waiting for the back end
  typedef struct packed {
    op_t         op;
    logic [15:0] coverage;
    logic        clipped;
    logic [9:0]  bin_index;
  } entry_t;

  typedef struct packed {
    logic init_busy;  // clearing pass after reset in progress
  } status_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int ACCW   = 100;  // signed accumulator for n*sumsq - sum^2
  localparam int SQXW   = 114;  // radicand width
  localparam int SQRW   = 57;   // root width
  localparam int DIVW   = 57;   // dividend width of the shared divider

endpackage

>>> src/chs_front.sv
// ----------------------------------------------------------------------------
// chs_front: input stage
// Sums the four base counts, flags top-bin saturation and pushes the beat.
// ----------------------------------------------------------------------------
module chs_front #(
  parameter int BINS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  chs_pkg::item_t  item,
  input  logic            item_valid,
  output logic            item_stall,
  input  chs_pkg::status_t status,
  input  logic            q_full,
  output logic            push,
  output chs_pkg::entry_t push_entry
);
  import chs_pkg::*;

  logic [15:0] cov;
  logic        busy_q;

  // hold stall through reset and one register behind init_busy, so the sweep is always seen
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= status.init_busy;
    end
  end

  assign cov = 16'(item.count_a) + 16'(item.count_g) + 16'(item.count_c)
             + 16'(item.count_t);

  assign item_stall = q_full | status.init_busy | busy_q;
  assign push       = item_valid & ~item_stall;

  always_comb begin
    push_entry.op        = item.op;
    push_entry.bin_index = item.bin_index;
    if (item.op == OP_ADD) begin
      push_entry.coverage = cov;
      push_entry.clipped  = ({1'b0, cov} >= 17'(BINS - 1));
    end else begin
      push_entry.coverage = '0;
      push_entry.clipped  = 1'b0;
    end
  end

endmodule

>>> src/chs_queue.sv
// ----------------------------------------------------------------------------
// chs_queue: short queue between front and back
// Four-entry FIFO of classified beats.
// ----------------------------------------------------------------------------
module chs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  chs_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output chs_pkg::entry_t head,
  output logic            empty
);
  import chs_pkg::*;

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full  = (fill == (QAW+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> src/chs_back.sv
// ----------------------------------------------------------------------------
// chs_back: execution stage
// Histogram memory, running sums, statistics sequencer and result register.
// ----------------------------------------------------------------------------
module chs_back #(
  parameter int BINS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  chs_pkg::entry_t   head,
  input  logic              q_empty,
  output logic              pop,
  output chs_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output chs_pkg::result_t  result
);
  import chs_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam logic [AW-1:0] TOP_BIN = AW'(BINS - 1);

  typedef enum logic [3:0] {
    S_CLR, S_CLRO, S_IDLE, S_ADD, S_RDB, S_MUL, S_SQ, S_DIVS, S_DIVM, S_REP
  } state_t;

  state_t state;

  logic [31:0] mem [BINS];
  logic [31:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  entry_t      cur;
  logic [AW-1:0] addr;
  logic [AW-1:0] head_addr;
  logic [AW-1:0] sweep;
  logic        clr_result;

  logic [31:0] position_total;
  logic [47:0] coverage_sum;
  logic [63:0] coverage_square_sum;
  logic [31:0] pos_next;
  logic        pos_full;

  // product sequencer
  logic [2:0]  mstep;
  logic [31:0] ma, mb;
  logic        m_sub;
  logic [1:0]  m_sh;
  logic [63:0] prod;
  logic        p_sub;
  logic [1:0]  p_sh;
  logic        pv;
  logic signed [ACCW-1:0] acc;
  logic [ACCW-1:0] term;

  // root
  logic [SQXW-1:0] sq_x;
  logic [SQRW-1:0] sq_r;
  logic [SQRW+1:0] sq_rem;
  logic [SQRW+3:0] rem_t;
  logic [SQRW+3:0] trial;
  logic            sq_ge;

  // divider
  logic [DIVW-1:0] dv;
  logic [31:0]     dr;
  logic [32:0]     rt;
  logic            d_ge;
  logic [DIVW-1:0] q_new;
  logic [5:0]      cnt;

  logic [23:0] std_res;
  logic [23:0] mean_res;
  logic        empty_flag;

  logic    can_load;
  logic    load;
  result_t res_d;

  assign can_load = ~result_valid | ~result_stall;
  assign pop      = (state == S_IDLE) & ~q_empty;
  assign status.init_busy = (state == S_CLR) & ~clr_result;

  always_comb begin
    if (head.op == OP_ADD) begin
      head_addr = head.clipped ? TOP_BIN : AW'(head.coverage);
    end else if (32'(head.bin_index) > 32'(BINS - 1)) begin
      head_addr = TOP_BIN;
    end else begin
      head_addr = AW'(head.bin_index);
    end
  end

  assign pos_full = (position_total == 32'hFFFF_FFFF);
  assign pos_next = pos_full ? position_total : position_total + 32'd1;

  // memory: one write port, one registered read port
  assign mem_we = (state == S_CLR) | ((state == S_ADD) & can_load);
  assign mem_wa = (state == S_CLR) ? sweep : addr;
  assign mem_wd = (state == S_CLR) ? 32'd0 :
                  (rd_data == 32'hFFFF_FFFF) ? rd_data : rd_data + 32'd1;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (pop)    rd_data     <= mem[head_addr];
  end

  // operand select for n*sumsq - sum^2, sum split as s1:s0
  always_comb begin
    ma = '0; mb = '0; m_sub = 1'b0; m_sh = 2'd0;
    case (mstep)
      3'd0: begin ma = position_total; mb = coverage_square_sum[31:0]; end
      3'd1: begin
        ma = position_total; mb = coverage_square_sum[63:32]; m_sh = 2'd1;
      end
      3'd2: begin
        ma = coverage_sum[31:0]; mb = coverage_sum[31:0]; m_sub = 1'b1;
      end
      3'd3, 3'd4: begin
        ma = coverage_sum[31:0]; mb = 32'(coverage_sum[47:32]);
        m_sub = 1'b1; m_sh = 2'd1;
      end
      3'd5: begin
        ma = 32'(coverage_sum[47:32]); mb = 32'(coverage_sum[47:32]);
        m_sub = 1'b1; m_sh = 2'd2;
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign term = ACCW'(prod) << {p_sh, 5'd0};

  // root step
  assign rem_t = {sq_rem, sq_x[SQXW-1 -: 2]};
  assign trial = {2'b00, sq_r, 2'b01};
  assign sq_ge = (rem_t >= trial);

  // divide step
  assign rt    = {dr, dv[DIVW-1]};
  assign d_ge  = (rt >= {1'b0, position_total});
  assign q_new = {dv[DIVW-2:0], d_ge};

  always_comb begin
    res_d = '0;
    load  = 1'b0;
    case (state)
      S_ADD: begin
        load           = can_load;
        res_d.coverage = cur.coverage;
        res_d.clipped  = cur.clipped;
        res_d.positions = pos_next;
      end
      S_RDB: begin
        load            = can_load;
        res_d.bin_count = rd_data;
        res_d.positions = position_total;
      end
      S_CLRO: begin
        load = can_load;
      end
      S_REP: begin
        load            = can_load;
        res_d.mean_q8   = mean_res;
        res_d.std_q8    = std_res;
        res_d.empty_res = empty_flag;
        res_d.positions = position_total;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_CLR;
      sweep               <= '0;
      clr_result          <= 1'b0;
      position_total      <= '0;
      coverage_sum        <= '0;
      coverage_square_sum <= '0;
      result_valid        <= 1'b0;
      pv                  <= 1'b0;
      mstep               <= '0;
      cnt                 <= '0;
    end else begin
      if (load) begin
        result       <= res_d;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == TOP_BIN) begin
            state <= clr_result ? S_CLRO : S_IDLE;
          end
        end
        S_CLRO: begin
          if (can_load) begin
            clr_result <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur  <= head;
            addr <= head_addr;
            case (head.op)
              OP_ADD:  state <= S_ADD;
              OP_READ: state <= S_RDB;
              OP_REPORT: begin
                if (position_total == '0) begin
                  empty_flag <= 1'b1;
                  mean_res   <= '0;
                  std_res    <= '0;
                  state      <= S_REP;
                end else begin
                  empty_flag <= 1'b0;
                  mstep      <= '0;
                  pv         <= 1'b0;
                  acc        <= '0;
                  state      <= S_MUL;
                end
              end
              default: begin
                position_total      <= '0;
                coverage_sum        <= '0;
                coverage_square_sum <= '0;
                sweep               <= '0;
                clr_result          <= 1'b1;
                state               <= S_CLR;
              end
            endcase
          end
        end
        S_ADD: begin
          if (can_load) begin
            if (!pos_full) begin
              position_total      <= pos_next;
              coverage_sum        <= coverage_sum + 48'(cur.coverage);
              coverage_square_sum <= coverage_square_sum
                                   + 64'(32'(cur.coverage) * 32'(cur.coverage));
            end
            state <= S_IDLE;
          end
        end
        S_RDB: begin
          if (can_load) state <= S_IDLE;
        end
        S_MUL: begin
          if (mstep != 3'd6) begin
            prod  <= 64'(ma) * 64'(mb);
            p_sub <= m_sub;
            p_sh  <= m_sh;
            pv    <= 1'b1;
            mstep <= mstep + 3'd1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            acc <= p_sub ? acc - signed'(term) : acc + signed'(term);
          end
          if (mstep == 3'd6 && !pv) begin
            sq_x   <= acc[ACCW-1] ? '0 : {acc[ACCW-3:0], 16'h0000};
            sq_r   <= '0;
            sq_rem <= '0;
            cnt    <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          sq_rem <= sq_ge ? (SQRW+2)'(rem_t - trial) : (SQRW+2)'(rem_t);
          sq_r   <= {sq_r[SQRW-2:0], sq_ge};
          sq_x   <= sq_x << 2;
          if (cnt == 6'(SQRW - 1)) begin
            dv    <= DIVW'({sq_r[SQRW-2:0], sq_ge});
            dr    <= '0;
            cnt   <= '0;
            state <= S_DIVS;
          end else begin
            cnt   <= cnt + 6'd1;
          end
        end
        S_DIVS, S_DIVM: begin
          if (cnt == 6'(DIVW - 1)) begin
            cnt <= '0;
            dr  <= '0;
            if (state == S_DIVS) begin
              std_res <= q_new[23:0];
              dv      <= {1'b0, coverage_sum, 8'h00};
              state   <= S_DIVM;
            end else begin
              mean_res <= q_new[23:0];
              state    <= S_REP;
            end
          end else begin
            dr  <= d_ge ? 32'(rt - {1'b0, position_total}) : rt[31:0];
            dv  <= q_new;
            cnt <= cnt + 6'd1;
          end
        end
        S_REP: begin
          if (can_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/coverage_histogram_stats_top.sv
// ----------------------------------------------------------------------------
// coverage_histogram_stats_top: coverage histogram with mean and std dev
// Front classifier, four-beat queue and back end with the histogram memory.
// ----------------------------------------------------------------------------
// Use:
//   item channel (item_valid / item_stall / item) takes one beat per op:
//   add a position, read a bin, report statistics, clear all. The result
//   channel (result_valid / result_stall / result) returns one beat per item.
// Work per item in the back end:
//   add and read make one memory read, registered, then the write-back or
//   result; report, when positions exist, runs six 32x32 partial products,
//   57 root steps and two 57-step divisions through one shared divider, and
//   goes straight to the result when empty; clear sweeps the memory, one
//   entry a cycle.
//   The front only computes coverage, so items queue up to four deep while
//   the back end works.
// Reset: a clearing pass runs over every entry of the histogram memory and
//   item_stall stays high until it has ended; no result comes
//   from it.
// Receiver stall: the result register holds its beat; the back end waits
//   with its next result, and the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module coverage_histogram_stats_top #(
  parameter int BINS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  chs_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output chs_pkg::result_t  result
);
  import chs_pkg::*;

  status_t status;
  entry_t  push_entry;
  entry_t  head;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;

  // classify and push
  chs_front #(.BINS(BINS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  chs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  // execute and deliver
  chs_back #(.BINS(BINS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  // an empty report carries no statistics and no positions
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.empty_res |->
      result.mean_q8 == '0 && result.std_q8 == '0 && result.positions == '0)
    else $error("empty report with non-zero statistics");

  // a clipped beat really reached the top bin
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clipped |-> 17'(result.coverage) >= 17'(BINS - 1))
    else $error("clipped flag below top bin");

  // no item taken right after reset, when the post-reset sweep begins
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> item_stall)
    else $error("item accepted during reset clearing pass");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for coverage_histogram_stats_top
// A short table of directed beats, then random add, read, report and clear
// beats under four idling phases; every result is checked against a typed
// expectation or a behavioural histogram and running-sum model in the bench.
// ----------------------------------------------------------------------------
module tb;
  import chs_pkg::*;

  localparam int NBINS = 1024;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  coverage_histogram_stats_top #(.BINS(NBINS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // directed stimulus row: typed rows carry a hand-written expectation
  typedef struct {
    item_t   beat;
    bit      typed;
    result_t want;
  } row_t;

  // model state of the histogram and the running sums
  logic [31:0] hist [NBINS];
  logic [31:0] n_positions;
  logic [63:0] cov_sum;
  logic [63:0] cov_sq_sum;

  result_t pending_results [$];
  row_t    rows [$];
  int      errors;
  int      send_idle_pct;
  int      stall_pct;
  int      n_add, n_read, n_report, n_clear, n_clip;
  logic [9:0] recent_cov [8];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: several times the slowest correct run
  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
  endtask

  function automatic logic [63:0] isqrt(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 56; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic void hist_wipe();
    for (int i = 0; i < NBINS; i++) hist[i] = '0;
    n_positions = '0;
    cov_sum     = '0;
    cov_sq_sum  = '0;
  endfunction

  // advance the histogram model by one beat and return its result
  function automatic result_t hist_step(input item_t b);
    result_t     r;
    logic [15:0] cov;
    logic [9:0]  bin;
    logic [127:0] nq, s2, d;
    r = '0;
    case (b.op)
      OP_ADD: begin
        cov = 16'(b.count_a) + 16'(b.count_g) + 16'(b.count_c) + 16'(b.count_t);
        r.coverage = cov;
        if (cov >= NBINS - 1) begin
          bin = 10'(NBINS - 1);
          r.clipped = 1'b1;
        end else begin
          bin = cov[9:0];
        end
        if (hist[bin] != '1) hist[bin]++;
        if (n_positions != '1) begin
          n_positions++;
          cov_sum    += 64'(cov);
          cov_sq_sum += 64'(cov) * 64'(cov);
        end
      end
      OP_READ: r.bin_count = hist[b.bin_index];
      OP_REPORT: begin
        if (n_positions == 0) begin
          r.empty_res = 1'b1;
        end else begin
          r.mean_q8 = 24'((cov_sum << 8) / 64'(n_positions));
          nq = 128'(n_positions) * 128'(cov_sq_sum);
          s2 = 128'(cov_sum) * 128'(cov_sum);
          d  = (nq < s2) ? '0 : nq - s2;
          d  = d << 16;
          r.std_q8 = 24'(isqrt(d) / 64'(n_positions));
        end
      end
      default: hist_wipe();
    endcase
    r.positions = n_positions;
    return r;
  endfunction

  function automatic item_t mk(input op_t op, input int a, input int g, input int c,
                               input int t, input int idx);
    item_t b;
    b.op = op;
    b.count_a = 14'(a);
    b.count_g = 14'(g);
    b.count_c = 14'(c);
    b.count_t = 14'(t);
    b.bin_index = 10'(idx);
    return b;
  endfunction

  function automatic result_t res(input int cov, input int bc, input int mean,
                                  input int pos, input bit empty, input bit clip);
    result_t r;
    r = '0;
    r.coverage  = 16'(cov);
    r.bin_count = 32'(bc);
    r.mean_q8   = 24'(mean);
    r.positions = 32'(pos);
    r.empty_res = empty;
    r.clipped   = clip;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input item_t beat, input bit typed, input result_t want);
    row_t x;
    x.beat  = beat;
    x.typed = typed;
    x.want  = want;
    rows = {rows, x};
  endfunction

  // one beat on the item channel; the model runs at acceptance
  task automatic send(input item_t b, input bit typed, input result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    do @(posedge clk); while (item_stall);
    r = hist_step(b);
    pending_results = {pending_results, typed ? want : r};
    case (b.op)
      OP_ADD: begin
        n_add++;
        n_clip += r.clipped;
        recent_cov[$urandom_range(7)] = r.coverage[9:0];
      end
      OP_READ:   n_read++;
      OP_REPORT: n_report++;
      default:   n_clear++;
    endcase
  endtask

  // receiver stall, redrawn every cycle
  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", result[63:0], 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (result.coverage !== w.coverage)
          report("coverage", 64'(result.coverage), 64'(w.coverage));
        if (result.bin_count !== w.bin_count)
          report("bin_count", 64'(result.bin_count), 64'(w.bin_count));
        if (result.mean_q8 !== w.mean_q8)
          report("mean_q8", 64'(result.mean_q8), 64'(w.mean_q8));
        if (result.std_q8 !== w.std_q8)
          report("std_q8", 64'(result.std_q8), 64'(w.std_q8));
        if (result.positions !== w.positions)
          report("positions", 64'(result.positions), 64'(w.positions));
        if (result.empty_res !== w.empty_res)
          report("empty_res", 64'(result.empty_res), 64'(w.empty_res));
        if (result.clipped !== w.clipped)
          report("clipped", 64'(result.clipped), 64'(w.clipped));
      end
    end
  end

  // random beat: mostly adds; half of the reads aim at bins drawn from recent add sums
  function automatic item_t random_beat();
    int    pick;
    int    lim;
    item_t b;
    pick = $urandom_range(999);
    lim  = ($urandom_range(9) < 2) ? 16383 : 255;
    b = mk(OP_ADD, $urandom_range(lim), $urandom_range(lim), $urandom_range(lim),
           $urandom_range(lim), $urandom_range(1023));
    if (pick >= 990)      b.op = OP_CLEAR;
    else if (pick >= 930) b.op = OP_REPORT;
    else if (pick >= 800) begin
      b.op = OP_READ;
      if ($urandom_range(1)) b.bin_index = recent_cov[$urandom_range(7)];
    end
    return b;
  endfunction

  initial begin
    result_t none;
    int      phase_idle [4];
    int      phase_stall [4];

    none = '0;
    errors = 0;
    n_add = 0; n_read = 0; n_report = 0; n_clear = 0; n_clip = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    foreach (recent_cov[i]) recent_cov[i] = '0;
    hist_wipe();
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table: empty state, the extremes, the top-bin edge, clear
    add_row(mk(OP_READ,   0, 0, 0, 0, 0),    1, res(0, 0, 0, 0, 0, 0));
    add_row(mk(OP_REPORT, 0, 0, 0, 0, 0),    1, res(0, 0, 0, 0, 1, 0));
    add_row(mk(OP_ADD,    0, 0, 0, 0, 0),    1, res(0, 0, 0, 1, 0, 0));
    add_row(mk(OP_ADD, 16383, 16383, 16383, 16383, 1023), 1,
            res(65532, 0, 0, 2, 0, 1));
    add_row(mk(OP_ADD, 1000, 22, 0, 0, 0),   1, res(1022, 0, 0, 3, 0, 0));
    add_row(mk(OP_ADD, 0, 0, 1023, 0, 0),    1, res(1023, 0, 0, 4, 0, 1));
    add_row(mk(OP_ADD, 0, 0, 0, 1024, 0),    1, res(1024, 0, 0, 5, 0, 1));
    add_row(mk(OP_READ, 0, 0, 0, 0, 1023),   1, res(0, 3, 0, 5, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, 0, 1022),   0, none);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0),      0, none);
    add_row(mk(OP_REPORT, 0, 0, 0, 0, 0),    0, none);
    add_row(mk(OP_ADD, 14'h2aaa, 14'h1555, 14'h2aaa, 14'h1555, 10'h2aa), 0, none);
    add_row(mk(OP_ADD, 14'h1555, 14'h2aaa, 14'h1555, 14'h2aaa, 10'h155), 0, none);
    add_row(mk(OP_READ, 0, 0, 0, 0, 10'h2aa), 0, none);
    add_row(mk(OP_READ, 0, 0, 0, 0, 10'h155), 0, none);
    add_row(mk(OP_REPORT, 0, 0, 0, 0, 0),    0, none);
    add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0),     1, res(0, 0, 0, 0, 0, 0));
    add_row(mk(OP_REPORT, 0, 0, 0, 0, 0),    1, res(0, 0, 0, 0, 1, 0));
    add_row(mk(OP_READ, 0, 0, 0, 0, 1023),   1, res(0, 0, 0, 0, 0, 0));
    add_row(mk(OP_ADD, 1, 1, 1, 1, 0),       1, res(4, 0, 0, 1, 0, 0));
    add_row(mk(OP_REPORT, 0, 0, 0, 0, 0),    1, res(0, 0, 1024, 1, 0, 0));

    foreach (rows[i]) send(rows[i].beat, rows[i].typed, rows[i].want);

    // random part in four idling phases; between phases the sender holds
    // off until every outstanding result has come back
    phase_idle  = '{0, 83, 0, 26};
    phase_stall = '{0, 0, 83, 26};
    for (int p = 0; p < 4; p++) begin
      item_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      for (int k = 0; k < 463; k++) begin
        // short bursts with no idling on either side
        if (k % 100 == 50) begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end else if (k % 100 == 70) begin
          send_idle_pct = phase_idle[p];
          stall_pct     = phase_stall[p];
        end
        send(random_beat(), 0, none);
      end
    end
    item_valid <= 1'b0;
    stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("tb: %0d adds (%0d into the top bin), %0d bin reads, %0d reports, %0d clears",
             n_add, n_clip, n_read, n_report, n_clear);
    $display("tb: idling phases none, sender, receiver and both were run");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
